/* sv/ovbp_pkg.sv */
`default_nettype none

package ovbp_pkg;

    localparam int FifoDepth = 4;
    localparam int PtrW      = $clog2(FifoDepth);
    localparam int CntW      = $clog2(FifoDepth + 1);

    localparam logic [1:0] CFG_INDEX_DEPTH = 2'd0;
    localparam logic [1:0] CFG_RANK_BASE   = 2'd1;

    localparam logic [3:0] DEPTH_MIN   = 4'd1;
    localparam logic [3:0] DEPTH_MAX   = 4'd8;
    localparam logic [3:0] DEPTH_RESET = 4'd8;

    // one packed byte with its end-of-stream mark
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } word_t;

    // queue status seen by the producer side
    typedef struct packed {
        logic [CntW-1:0] count;
        logic            has_room;
    } fifo_status_t;

    function automatic logic [3:0] eff_depth(input logic [3:0] depth);
        logic [3:0] d;
        d = depth;
        if (depth == 4'd0) begin
            d = DEPTH_MIN;
        end else if (depth > DEPTH_MAX) begin
            d = DEPTH_MAX;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

/* sv/ovbp_fifo.sv */
`default_nettype none

module ovbp_fifo
    import ovbp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [1:0]   push_cnt,
    input  wire word_t        push0,
    input  wire word_t        push1,
    input  wire logic         pop,
    output word_t             head,
    output fifo_status_t      status
);

    word_t           entries_reg [FifoDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [PtrW-1:0] wr_ptr_plus1;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign wr_ptr_plus1 = wr_ptr_reg + PtrW'(1);
    assign wr_ptr_next  = wr_ptr_reg + PtrW'(push_cnt);
    assign rd_ptr_next  = rd_ptr_reg + PtrW'(pop);
    assign count_next   = count_reg + CntW'(push_cnt) - CntW'(pop);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push_cnt != 2'd0) begin
            entries_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            entries_reg[wr_ptr_plus1] <= push1;
        end
    end

    assign head            = entries_reg[rd_ptr_reg];
    assign status.count    = count_reg;
    // room for the largest burst a single input word can cause
    assign status.has_room = (count_reg <= CntW'(FifoDepth - 2));

endmodule

`default_nettype wire

/* sv/offset_variable_width_bit_packer.sv */
`default_nettype none

// Packs one rank per input word as a (rank - rank_base) index of index_depth bits
// into an LSB-first byte stream. One word is taken per cycle while in_stall is low;
// a completed byte is registered into the output queue behind any bytes waiting
// there. The word marked last_rank flushes the partial byte and sets final_byte on
// the last byte it emits, so it can produce two. Bytes leave a four-entry queue one
// per cycle while out_stall is low; input stalls while it holds more than two bytes.
// index_depth and rank_base may only be written while the block is idle.

module offset_variable_width_bit_packer
    import ovbp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rank,
    input  wire logic       last_rank,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      packed_byte,
    output logic            final_byte
);

    logic [3:0]  depth_reg;
    logic [7:0]  base_reg;
    logic [6:0]  pend_bits_reg;
    logic [6:0]  pend_bits_next;
    logic [2:0]  pend_cnt_reg;
    logic [2:0]  pend_cnt_next;

    logic        in_acc;
    logic        pop;
    logic [3:0]  depth;
    logic [7:0]  idx_mask;
    logic [7:0]  idx;
    logic [14:0] acc;
    logic [3:0]  total;
    logic        full;
    logic [6:0]  rem_bits;
    logic [2:0]  rem_cnt;
    logic [7:0]  flush_mask;
    logic [7:0]  flush_byte;
    logic        has_flush;
    logic [1:0]  push_cnt;
    word_t       push0;
    word_t       push1;
    word_t       head;
    fifo_status_t fstat;

    assign in_stall = !fstat.has_room;
    assign in_acc   = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            depth_reg <= DEPTH_RESET;
            base_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_INDEX_DEPTH: depth_reg <= cfg_data[3:0];
                CFG_RANK_BASE:   base_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign depth    = eff_depth(depth_reg);
    assign idx_mask = 8'((9'd1 << depth) - 9'd1);
    assign idx      = (rank - base_reg) & idx_mask;
    assign acc      = {8'd0, pend_bits_reg} | (15'(idx) << pend_cnt_reg);
    assign total    = {1'b0, pend_cnt_reg} + depth;
    assign full     = total[3];

    // after a full byte leaves, what is left always fits in seven bits
    assign rem_bits   = full ? acc[14:8] : acc[6:0];
    assign rem_cnt    = total[2:0];
    assign flush_mask = 8'((9'd1 << rem_cnt) - 9'd1);
    assign flush_byte = {1'b0, rem_bits} & flush_mask;
    assign has_flush  = last_rank && (rem_cnt != 3'd0);

    always_comb begin
        push_cnt = '0;
        push1.data = flush_byte;
        push1.fin  = 1'b1;
        if (full) begin
            push0.data = acc[7:0];
            push0.fin  = last_rank && !has_flush;
        end else begin
            push0.data = flush_byte;
            push0.fin  = 1'b1;
        end
        if (in_acc) begin
            push_cnt = {1'b0, full} + {1'b0, has_flush};
        end
    end

    assign pend_bits_next = last_rank ? 7'd0 : rem_bits;
    assign pend_cnt_next  = last_rank ? 3'd0 : rem_cnt;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end else if (in_acc) begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

    ovbp_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .push0    (push0),
        .push1    (push1),
        .pop      (pop),
        .head     (head),
        .status   (fstat)
    );

    assign out_valid   = (fstat.count != '0);
    assign packed_byte = head.data;
    assign final_byte  = head.fin;

    // queue never overflows its storage
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fstat.count <= CntW'(FifoDepth))
        else $error("output queue count out of range");

    // the last word always leaves the bit buffer empty
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && last_rank |=> pend_cnt_reg == 3'd0 && pend_bits_reg == 7'd0)
        else $error("bit buffer not cleared after last word");

    // buffered bits above the valid count stay zero
    a_pend_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_bits_reg & ~7'((8'd1 << pend_cnt_reg) - 8'd1)) == 7'd0)
        else $error("stray bits above pending count");

    // a two-byte burst only comes from a last word
    a_burst_last: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt == 2'd2 |-> in_acc && last_rank)
        else $error("two bytes pushed without a last word");

endmodule

`default_nettype wire

/* tb/sv/packed_byte_checker.sv */
`default_nettype none

module packed_byte_checker
    import ovbp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [7:0] rank,
    input  wire logic       last_rank,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [7:0] packed_byte,
    input  wire logic       final_byte,
    output int              bytes_owed,
    output int              mismatches
);

    logic [3:0] depth_reg;
    logic [7:0] base_reg;
    logic [6:0] held_bits;
    logic [2:0] held_count;
    word_t      bytes_due[$];
    word_t      oldest;
    int         errors;

    // appends the index of one rank word and queues every byte it completes or flushes
    function automatic void pack_rank(input logic [7:0] r, input logic close);
        logic [3:0]  width;
        logic [7:0]  index;
        logic [14:0] acc;
        int          total;
        word_t       first;
        word_t       flush;
        logic        have_first;
        if (depth_reg == 4'd0) begin
            width = DEPTH_MIN;
        end else if (depth_reg > DEPTH_MAX) begin
            width = DEPTH_MAX;
        end else begin
            width = depth_reg;
        end
        index = r - base_reg;
        index = index & (8'hff >> (4'd8 - width));
        acc = {8'd0, held_bits} | (15'(index) << held_count);
        total = int'(held_count) + int'(width);
        have_first = 1'b0;
        first = '0;
        if (total >= 8) begin
            first.data = acc[7:0];
            first.fin = 1'b0;
            have_first = 1'b1;
            acc = acc >> 8;
            total = total - 8;
        end
        if (close) begin
            // nothing left to flush: the completed byte closes the stream
            if (total == 0 && have_first) begin
                first.fin = 1'b1;
            end
            if (have_first) begin
                bytes_due.push_back(first);
            end
            if (total > 0) begin
                flush.data = acc[7:0] & (8'hff >> (8 - total));
                flush.fin = 1'b1;
                bytes_due.push_back(flush);
            end
            held_bits = '0;
            held_count = '0;
        end else begin
            if (have_first) begin
                bytes_due.push_back(first);
            end
            held_bits = acc[6:0];
            held_count = total[2:0];
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            depth_reg = DEPTH_RESET;
            base_reg = '0;
            held_bits = '0;
            held_count = '0;
            bytes_due.delete();
            errors = 0;
            bytes_owed <= 0;
            mismatches <= 0;
        end else begin
            // a word leaving now was caused by an earlier input, so pop first
            if (out_valid && !out_stall) begin
                if (bytes_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word: expected none, got byte %02h final %b",
                             $time, packed_byte, final_byte);
                end else begin
                    oldest = bytes_due.pop_front();
                    if (packed_byte !== oldest.data) begin
                        errors++;
                        $display("%0t: packed_byte mismatch: expected %02h, got %02h",
                                 $time, oldest.data, packed_byte);
                    end
                    if (final_byte !== oldest.fin) begin
                        errors++;
                        $display("%0t: final_byte mismatch: expected %b, got %b",
                                 $time, oldest.fin, final_byte);
                    end
                end
            end
            if (in_valid && !in_stall) begin
                pack_rank(rank, last_rank);
            end
            if (cfg_we) begin
                if (cfg_index == CFG_INDEX_DEPTH) begin
                    depth_reg = cfg_data[3:0];
                end else if (cfg_index == CFG_RANK_BASE) begin
                    base_reg = cfg_data;
                end
            end
            bytes_owed <= bytes_due.size();
            mismatches <= errors;
        end
    end

endmodule

`default_nettype wire

/* tb/sv/tb_offset_variable_width_bit_packer.sv */
`default_nettype none

module tb_offset_variable_width_bit_packer;
    import ovbp_pkg::*;

    // indexes past the register list, writes there must be ignored
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;

    localparam int WatchdogLimit = 2000;
    localparam int DrainCycles   = 4;
    localparam int RandomItems   = 1400;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] rank;
    logic       last_rank;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] packed_byte;
    logic       final_byte;

    int         bytes_owed;
    int         mismatches;
    int         sender_idle_pct;
    int         receiver_idle_pct;
    int         items_sent;
    int         quiet_cycles = 0;
    int         cur_width;
    logic [7:0] cur_base;

    offset_variable_width_bit_packer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rank        (rank),
        .last_rank   (last_rank),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .packed_byte (packed_byte),
        .final_byte  (final_byte)
    );

    packed_byte_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rank        (rank),
        .last_rank   (last_rank),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .packed_byte (packed_byte),
        .final_byte  (final_byte),
        .bytes_owed  (bytes_owed),
        .mismatches  (mismatches)
    );

    always #5 clk = ~clk;

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WatchdogLimit) begin
                $display("offset_variable_width_bit_packer verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_rank(input logic [7:0] r, input logic close);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rank <= r;
        last_rank <= close;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (bytes_owed != 0) begin
            @(negedge clk);
        end
        // a word that completes no byte may still be in flight
        repeat (DrainCycles) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_INDEX_DEPTH) begin
            if (val[3:0] == 4'd0) begin
                cur_width = int'(DEPTH_MIN);
            end else if (val[3:0] > DEPTH_MAX) begin
                cur_width = int'(DEPTH_MAX);
            end else begin
                cur_width = int'(val[3:0]);
            end
        end else if (idx == CFG_RANK_BASE) begin
            cur_base = val;
        end
    endtask

    // half the ranks are built so their index fits the depth, the rest are fully random
    task automatic send_sequence(input int len, input logic close);
        logic [7:0] r;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(1) == 0) begin
                r = 8'($urandom);
            end else begin
                r = cur_base + (8'($urandom) & (8'hff >> (8 - cur_width)));
            end
            send_rank(r, close && (k == len - 1));
        end
    endtask

    task automatic random_segment();
        logic [3:0] depth_val;
        logic [7:0] base_val;
        int         seqs;
        int         len;
        pause_until_drained();
        case ($urandom_range(9))
            0: depth_val = 4'd0;
            1: depth_val = 4'($urandom_range(9, 15));
            2: depth_val = DEPTH_MIN;
            3: depth_val = DEPTH_MAX;
            default: depth_val = 4'($urandom_range(1, 8));
        endcase
        write_reg(CFG_INDEX_DEPTH, {4'($urandom), depth_val});
        case ($urandom_range(5))
            0: base_val = 8'h00;
            1: base_val = 8'hff;
            default: base_val = 8'($urandom);
        endcase
        if ($urandom_range(3) != 0) begin
            write_reg(CFG_RANK_BASE, base_val);
        end
        if ($urandom_range(7) == 0) begin
            write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 8'($urandom));
        end
        seqs = $urandom_range(1, 4);
        for (int s = 0; s < seqs; s++) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
            // leaving the last one open carries buffered bits across a depth change
            send_sequence(len, !(s == seqs - 1 && $urandom_range(4) == 0));
        end
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_INDEX_DEPTH;
        cfg_data = '0;
        in_valid = 1'b0;
        rank = '0;
        last_rank = 1'b0;
        out_stall = 1'b0;
        items_sent = 0;
        cur_width = int'(DEPTH_RESET);
        cur_base = '0;
        sender_idle_pct = 20;
        receiver_idle_pct = 81;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset setting, full-width bytes, stream closes on a completed byte
        send_rank(8'h00, 1'b0);
        send_rank(8'hff, 1'b0);
        send_rank(8'ha5, 1'b1);

        pause_until_drained();
        write_reg(CFG_SPARE_LO, 8'h03);
        write_reg(CFG_SPARE_HI, 8'hfc);
        send_rank(8'h5a, 1'b1);

        // depth zero acts as one bit
        pause_until_drained();
        write_reg(CFG_INDEX_DEPTH, 8'h00);
        send_rank(8'h01, 1'b0);
        send_rank(8'h00, 1'b0);
        send_rank(8'hff, 1'b1);

        // depth above eight acts as eight, base wraps the index
        pause_until_drained();
        write_reg(CFG_INDEX_DEPTH, 8'hff);
        write_reg(CFG_RANK_BASE, 8'hff);
        send_rank(8'h00, 1'b0);
        send_rank(8'hfe, 1'b1);

        // wide index masked, last word both completes a byte and flushes one
        pause_until_drained();
        write_reg(CFG_INDEX_DEPTH, 8'h83);
        write_reg(CFG_RANK_BASE, 8'h80);
        send_rank(8'h7f, 1'b0);
        send_rank(8'h80, 1'b0);
        send_rank(8'h85, 1'b1);

        // depth change with bits still buffered
        pause_until_drained();
        write_reg(CFG_INDEX_DEPTH, 8'h05);
        write_reg(CFG_RANK_BASE, 8'h00);
        send_rank(8'h1f, 1'b0);
        pause_until_drained();
        write_reg(CFG_INDEX_DEPTH, 8'h07);
        send_rank(8'h7f, 1'b1);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 20;
                    receiver_idle_pct = 81;
                end
                1: begin
                    sender_idle_pct = 81;
                    receiver_idle_pct = 20;
                end
                default: begin
                    sender_idle_pct = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            while (items_sent < (phase + 1) * RandomItems / 3) begin
                random_segment();
            end
        end
        send_sequence(1, 1'b1);

        pause_until_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && bytes_owed == 0) begin
            $display("offset_variable_width_bit_packer verification clean");
        end else begin
            $display("offset_variable_width_bit_packer verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
